>>> src/iqdh_pkg.sv
// Shared constants and codes of the I/Q density histogram.
// No dependencies; the top level and benches take names from here by scope.

package iqdh_pkg;

   // Defaults for the top-level parameters
   localparam int BIN_SIDE_DEF  = 256;
   localparam int FRAC_BITS_DEF = 8;

   // Fixed field widths
   localparam int SAMPLE_W  = 8;
   localparam int STEP_W    = 16;
   localparam int STEP_FRAC = 8;
   localparam int VALUE_W   = 16;
   localparam int CSR_IDX_W = 1;

   // Largest bin level in whole units
   localparam int LEVEL_INT_MAX = 255;

   // Clear generations kept in each stored word; a full pass runs on wrap
   localparam int EPOCH_BITS = 6;

   localparam logic [STEP_W-1:0] STEP_RESET = 16'd8;

   typedef enum logic {
      FUNC_ACCUM = 1'b0,
      FUNC_READ  = 1'b1
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAUSED = 1'b0,
      CSR_STEP   = 1'b1
   } csr_index_type;

endpackage

>>> src/iqdh_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// A read and a write to the same entry in one cycle return the old word.
// No dependencies.

module iqdh_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> src/iq_density_histogram.sv
// Top level of the I/Q density histogram. Depends on iqdh_pkg and iqdh_ram.
//
// The block takes one item per clock cycle while req_ready is high. Every item
// reads its bin from one synchronous RAM in the cycle of its transfer; an
// unpaused accumulate on an in-range bin writes the new level back in the next
// cycle, and a write that meets a read of the same bin in the next item is
// forwarded. A read item's result enters a two-entry output queue in the cycle
// after its transfer. Each stored word carries a clear generation, so a block
// clear needs no pass: a word from an older generation reads as zero. A block
// clear that finds the generation count at its top (the 64th after reset, then
// every 63rd, for 2**EPOCH_BITS generations) and the end of reset start a pass
// over all 4**ceil(log2(BIN_SIDE)) bins (65536 by default), one bin per cycle,
// during which no item is taken; configuration writes are taken at any time.

module iq_density_histogram #(
   parameter int BIN_SIDE  = iqdh_pkg::BIN_SIDE_DEF,
   parameter int FRAC_BITS = iqdh_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                csr_write_en,
   input  logic [iqdh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [iqdh_pkg::STEP_W-1:0]         csr_wdata,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [iqdh_pkg::SAMPLE_W-1:0]       req_i_sample,
   input  logic [iqdh_pkg::SAMPLE_W-1:0]       req_q_sample,
   input  logic                                req_first_of_block,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [iqdh_pkg::VALUE_W-1:0]        rsp_bin_value
);

   localparam int COORD_W = $clog2(BIN_SIDE);
   localparam int EXT_W   = (COORD_W > iqdh_pkg::SAMPLE_W) ? COORD_W : iqdh_pkg::SAMPLE_W;
   localparam int ADDR_W  = 2 * COORD_W;
   localparam int DEPTH   = 1 << ADDR_W;
   localparam int LEVEL_W = 8 + FRAC_BITS;
   localparam int EP_W    = iqdh_pkg::EPOCH_BITS;
   localparam int WORD_W  = EP_W + LEVEL_W;
   localparam int SHL     = (FRAC_BITS >= iqdh_pkg::STEP_FRAC) ?
                            FRAC_BITS - iqdh_pkg::STEP_FRAC : 0;
   localparam int SHR     = (FRAC_BITS < iqdh_pkg::STEP_FRAC) ?
                            iqdh_pkg::STEP_FRAC - FRAC_BITS : 0;
   localparam int SUM_W   = iqdh_pkg::STEP_W + SHL + 2;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX =
      LEVEL_W'(iqdh_pkg::LEVEL_INT_MAX << FRAC_BITS);

   // Configuration
   logic                                paused_ff;
   logic signed [iqdh_pkg::STEP_W-1:0]  step_ff;

   // Clearing pass and clear generation
   logic              sweep_ff, sweep_in;
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [EP_W-1:0]   epoch_ff, epoch_in;

   // Read-modify-write stage
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_read_ff;
   logic              s1_ok_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [EP_W-1:0]   s1_epoch_ff;

   // Last written word, for the next item's read
   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [WORD_W-1:0] fwd_word_ff;

   // Output queue
   logic [1:0]                     q_count_ff, q_count_in;
   logic [iqdh_pkg::VALUE_W-1:0]   q0_ff, q0_in, q1_ff, q1_in;

   logic                  accept, acc_live, block_clear, wrap_req, sweep_start;
   logic                  coord_ok;
   logic [EXT_W-1:0]      i_ext, q_ext;
   logic [ADDR_W-1:0]     req_addr;
   logic [2:0]            credit;
   logic                  pop, push;
   logic [iqdh_pkg::VALUE_W-1:0] push_value;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [WORD_W-1:0]     wr_data;
   logic [WORD_W-1:0]     rd_data;
   logic [WORD_W-1:0]     cur_word;
   logic [LEVEL_W-1:0]    old_level, new_level;
   logic signed [SUM_W-1:0] step_ext, step_scaled, sum;

   // ---------------------------------------------------------------- decode
   assign i_ext    = EXT_W'(req_i_sample);
   assign q_ext    = EXT_W'(req_q_sample);
   assign req_addr = {q_ext[COORD_W-1:0], i_ext[COORD_W-1:0]};
   assign coord_ok = (32'(req_i_sample) < BIN_SIDE) && (32'(req_q_sample) < BIN_SIDE);

   assign pop    = rsp_valid && rsp_ready;
   assign credit = 3'(q_count_ff) - 3'(pop) + 3'(s1_valid_ff && s1_read_ff);

   // A clear at the last generation waits for a full pass
   assign wrap_req = req_valid && (req_func == iqdh_pkg::FUNC_ACCUM) &&
                     req_first_of_block && !paused_ff && (&epoch_ff);
   assign sweep_start = wrap_req && !sweep_ff && !s1_valid_ff;

   assign req_ready   = !sweep_ff && !wrap_req && (credit < 3'd2);
   assign accept      = req_valid && req_ready;
   assign acc_live    = accept && (req_func == iqdh_pkg::FUNC_ACCUM) && !paused_ff;
   assign block_clear = acc_live && req_first_of_block;

   always_comb begin
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      epoch_in      = epoch_ff;
      if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
         if (&sweep_addr_ff) begin
            sweep_in = 1'b0;
            epoch_in = '0;
         end
      end else if (sweep_start) begin
         sweep_in      = 1'b1;
         sweep_addr_in = '0;
      end else if (block_clear) begin
         epoch_in = epoch_ff + 1'b1;
      end
   end

   assign s1_valid_in = accept && ((req_func == iqdh_pkg::FUNC_READ) || (acc_live && coord_ok));

   // ---------------------------------------------------------------- memory
   iqdh_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_bins (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------- update
   assign cur_word  = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_word_ff : rd_data;
   assign old_level = (cur_word[WORD_W-1:LEVEL_W] == s1_epoch_ff) ?
                      cur_word[LEVEL_W-1:0] : '0;

   assign step_ext    = SUM_W'(step_ff);
   assign step_scaled = (step_ext <<< SHL) >>> SHR;
   assign sum         = $signed({{(SUM_W-LEVEL_W){1'b0}}, old_level}) + step_scaled;

   always_comb begin
      if (sum[SUM_W-1]) begin
         new_level = '0;
      end else if (sum[SUM_W-2:0] > (SUM_W-1)'(LEVEL_MAX)) begin
         new_level = LEVEL_MAX;
      end else begin
         new_level = LEVEL_W'(sum[SUM_W-2:0]);
      end
   end

   always_comb begin
      if (sweep_ff) begin
         wr_en   = 1'b1;
         wr_addr = sweep_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_valid_ff && !s1_read_ff;
         wr_addr = s1_addr_ff;
         wr_data = {s1_epoch_ff, new_level};
      end
   end

   // ---------------------------------------------------------------- output queue
   assign push       = s1_valid_ff && s1_read_ff;
   assign push_value = s1_ok_ff ? iqdh_pkg::VALUE_W'(old_level) : '0;

   always_comb begin
      q0_in      = q0_ff;
      q1_in      = q1_ff;
      q_count_in = q_count_ff + 2'(push) - 2'(pop);
      case (q_count_ff)
         2'd0: begin
            if (push) begin
               q0_in = push_value;
            end
         end
         2'd1: begin
            if (pop && push) begin
               q0_in = push_value;
            end else if (push) begin
               q1_in = push_value;
            end
         end
         2'd2: begin
            if (pop) begin
               q0_in = q1_ff;
               if (push) begin
                  q1_in = push_value;
               end
            end
         end
         default: begin
            q_count_in = q_count_ff;
         end
      endcase
   end

   assign rsp_valid     = (q_count_ff != 2'd0);
   assign rsp_bin_value = q0_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         paused_ff     <= 1'b0;
         step_ff       <= $signed(iqdh_pkg::STEP_RESET);
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
         epoch_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         q_count_ff    <= '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               iqdh_pkg::CSR_PAUSED: paused_ff <= csr_wdata[0];
               iqdh_pkg::CSR_STEP:   step_ff   <= $signed(csr_wdata);
               default: ;
            endcase
         end
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
         epoch_ff      <= epoch_in;
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= wr_en;
         q_count_ff    <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_read_ff  <= (req_func == iqdh_pkg::FUNC_READ);
      s1_ok_ff    <= coord_ok;
      s1_addr_ff  <= req_addr;
      s1_epoch_ff <= epoch_in;
      fwd_addr_ff <= wr_addr;
      fwd_word_ff <= wr_data;
      q0_ff       <= q0_in;
      q1_ff       <= q1_in;
   end

endmodule

>>> test/iqdh_density_checker.sv
// Checker for the I/Q density histogram: watches the register, sample and result ports,
// keeps its own copy of the bin store and compares every returned bin level.
// Depends on iqdh_pkg for widths, codes and the step reset value.

module iqdh_density_checker #(
   parameter int BIN_SIDE  = iqdh_pkg::BIN_SIDE_DEF,
   parameter int FRAC_BITS = iqdh_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           csr_write_en,
   input  logic [iqdh_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [iqdh_pkg::STEP_W-1:0]    csr_wdata,

   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_func,
   input  logic [iqdh_pkg::SAMPLE_W-1:0]  req_i_sample,
   input  logic [iqdh_pkg::SAMPLE_W-1:0]  req_q_sample,
   input  logic                           req_first_of_block,

   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [iqdh_pkg::VALUE_W-1:0]   rsp_bin_value,

   output int                             fail_count,
   output int                             pending
);

   localparam int BIN_COUNT = BIN_SIDE * BIN_SIDE;
   localparam int LEVEL_TOP = iqdh_pkg::LEVEL_INT_MAX << FRAC_BITS;

   // A bin counts only if it was written in the current clear generation
   int                                 bin_level [BIN_COUNT];
   int unsigned                        bin_epoch [BIN_COUNT];
   int unsigned                        clear_epoch = 1;
   logic                               paused_q = 1'b0;
   logic signed [iqdh_pkg::STEP_W-1:0] step_q = iqdh_pkg::STEP_RESET;
   logic [iqdh_pkg::VALUE_W-1:0]       read_values [$];
   int                                 errors = 0;

   function automatic int scaled_step(logic signed [iqdh_pkg::STEP_W-1:0] s);
      int v;
      v = s;
      if (FRAC_BITS >= iqdh_pkg::STEP_FRAC)
         return v <<< (FRAC_BITS - iqdh_pkg::STEP_FRAC);
      return v >>> (iqdh_pkg::STEP_FRAC - FRAC_BITS);
   endfunction

   function automatic int level_at(int unsigned addr);
      return (bin_epoch[addr] == clear_epoch) ? bin_level[addr] : 0;
   endfunction

   task automatic report_mismatch(string msg);
      $display("%0t checker: %s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin : watch
      int unsigned                  addr;
      bit                           hit;
      int                           sum;
      logic [iqdh_pkg::VALUE_W-1:0] want;
      if (reset) begin
         clear_epoch++;
         paused_q = 1'b0;
         step_q = iqdh_pkg::STEP_RESET;
         read_values.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               iqdh_pkg::CSR_PAUSED: paused_q = csr_wdata[0];
               iqdh_pkg::CSR_STEP:   step_q = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            hit = (int'(req_i_sample) < BIN_SIDE) && (int'(req_q_sample) < BIN_SIDE);
            addr = int'(req_q_sample) * BIN_SIDE + int'(req_i_sample);
            if (req_func == iqdh_pkg::FUNC_READ) begin
               want = hit ? iqdh_pkg::VALUE_W'(level_at(addr)) : '0;
               read_values.push_back(want);
            end else if (!paused_q) begin
               if (req_first_of_block)
                  clear_epoch++;
               if (hit) begin
                  sum = level_at(addr) + scaled_step(step_q);
                  if (sum < 0)
                     sum = 0;
                  if (sum > LEVEL_TOP)
                     sum = LEVEL_TOP;
                  bin_level[addr] = sum;
                  bin_epoch[addr] = clear_epoch;
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (read_values.size() == 0) begin
               report_mismatch($sformatf("bin_value %0d with no read outstanding",
                                         rsp_bin_value));
            end else begin
               want = read_values.pop_front();
               if (rsp_bin_value !== want)
                  report_mismatch($sformatf("bin_value expected %0d, got %0d",
                                            want, rsp_bin_value));
            end
         end
      end
      fail_count <= errors;
      pending <= read_values.size();
   end

endmodule

>>> test/iq_density_histogram_tb.sv
// Top of the I/Q density histogram testbench: clock, reset, register writes and
// sample/read traffic under varying stalls. Depends on iqdh_pkg, iq_density_histogram
// and iqdh_density_checker, which predicts and compares the returned bin levels.

module iq_density_histogram_tb;

   localparam int     CLOCK_HALF      = 6;
   localparam int     PHASES          = 12;
   localparam int     ITEMS_PER_PHASE = 160;
   localparam longint LIMIT_CYCLES    = 4_000_000;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_write_en;
   logic [iqdh_pkg::CSR_IDX_W-1:0] csr_index;
   logic [iqdh_pkg::STEP_W-1:0]    csr_wdata;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_func;
   logic [iqdh_pkg::SAMPLE_W-1:0]  req_i_sample;
   logic [iqdh_pkg::SAMPLE_W-1:0]  req_q_sample;
   logic                           req_first_of_block;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [iqdh_pkg::VALUE_W-1:0]   rsp_bin_value;

   int fail_count;
   int pending;
   int send_idle = 0;
   int recv_idle = 0;
   int n_reads = 0;
   int n_accums = 0;
   int n_clears = 0;
   int n_settings = 0;
   logic cur_paused = 1'b0;
   logic [iqdh_pkg::SAMPLE_W-1:0] pool_i [8];
   logic [iqdh_pkg::SAMPLE_W-1:0] pool_q [8];

   always #CLOCK_HALF clock = ~clock;

   iq_density_histogram dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_i_sample       (req_i_sample),
      .req_q_sample       (req_q_sample),
      .req_first_of_block (req_first_of_block),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_bin_value      (rsp_bin_value)
   );

   iqdh_density_checker #(
      .BIN_SIDE  (iqdh_pkg::BIN_SIDE_DEF),
      .FRAC_BITS (iqdh_pkg::FRAC_BITS_DEF)
   ) density_check (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_i_sample       (req_i_sample),
      .req_q_sample       (req_q_sample),
      .req_first_of_block (req_first_of_block),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_bin_value      (rsp_bin_value),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // Hold the item until its transfer; valid goes low only over an idle gap
   task automatic send_item(iqdh_pkg::func_type func, logic [iqdh_pkg::SAMPLE_W-1:0] i,
                            logic [iqdh_pkg::SAMPLE_W-1:0] q, logic first);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle && gap < 40)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_i_sample <= i;
      req_q_sample <= q;
      req_first_of_block <= first;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (func == iqdh_pkg::FUNC_READ) begin
         n_reads++;
      end else begin
         n_accums++;
         if (first && !cur_paused)
            n_clears++;
      end
   endtask

   // Drain outstanding reads, then let the last write-back land
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_config(logic paused, logic [iqdh_pkg::STEP_W-1:0] step);
      csr_write_en <= 1'b1;
      csr_index <= iqdh_pkg::CSR_PAUSED;
      csr_wdata <= {{(iqdh_pkg::STEP_W-1){1'b0}}, paused};
      @(posedge clock);
      csr_index <= iqdh_pkg::CSR_STEP;
      csr_wdata <= step;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_paused = paused;
      n_settings++;
   endtask

   // Mostly a few hot bins, so reads see built-up levels and same-bin hazards
   task automatic random_item();
      logic [iqdh_pkg::SAMPLE_W-1:0] i;
      logic [iqdh_pkg::SAMPLE_W-1:0] q;
      int                            k;
      iqdh_pkg::func_type            f;
      logic                          first;
      k = $urandom_range(0, 7);
      if ($urandom_range(0, 9) < 7) begin
         i = pool_i[k];
         q = pool_q[k];
      end else begin
         i = iqdh_pkg::SAMPLE_W'($urandom_range(0, 255));
         q = iqdh_pkg::SAMPLE_W'($urandom_range(0, 255));
      end
      f = ($urandom_range(0, 9) < 4) ? iqdh_pkg::FUNC_READ : iqdh_pkg::FUNC_ACCUM;
      if (f == iqdh_pkg::FUNC_READ)
         first = 1'($urandom_range(0, 1));
      else
         first = ($urandom_range(0, 11) == 0);
      send_item(f, i, q, first);
   endtask

   initial begin : stimulus
      int                          p;
      logic [iqdh_pkg::STEP_W-1:0] step;
      logic                        pz;
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= iqdh_pkg::CSR_PAUSED;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_func <= iqdh_pkg::FUNC_ACCUM;
      req_i_sample <= '0;
      req_q_sample <= '0;
      req_first_of_block <= 1'b0;
      pool_i[0] = 8'd0;   pool_q[0] = 8'd0;
      pool_i[1] = 8'd255; pool_q[1] = 8'd255;
      pool_i[2] = 8'd0;   pool_q[2] = 8'd255;
      pool_i[3] = 8'd255; pool_q[3] = 8'd0;
      for (int n = 4; n < 8; n++) begin
         pool_i[n] = iqdh_pkg::SAMPLE_W'($urandom_range(0, 255));
         pool_q[n] = iqdh_pkg::SAMPLE_W'($urandom_range(0, 255));
      end
      send_idle = 9;
      recv_idle = 48;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Saturation at the top, with repeated hits on one bin
      write_config(1'b0, 16'h7FFF);
      send_item(iqdh_pkg::FUNC_READ, 8'd0, 8'd0, 1'b0);
      send_item(iqdh_pkg::FUNC_READ, 8'd255, 8'd255, 1'b0);
      send_item(iqdh_pkg::FUNC_ACCUM, 8'd255, 8'd0, 1'b0);
      send_item(iqdh_pkg::FUNC_ACCUM, 8'd255, 8'd0, 1'b0);
      send_item(iqdh_pkg::FUNC_ACCUM, 8'd255, 8'd0, 1'b0);
      send_item(iqdh_pkg::FUNC_READ, 8'd255, 8'd0, 1'b0);
      // Saturation at zero
      settle();
      write_config(1'b0, 16'h8000);
      send_item(iqdh_pkg::FUNC_ACCUM, 8'd255, 8'd0, 1'b0);
      send_item(iqdh_pkg::FUNC_ACCUM, 8'd255, 8'd0, 1'b0);
      send_item(iqdh_pkg::FUNC_READ, 8'd255, 8'd0, 1'b0);
      send_item(iqdh_pkg::FUNC_READ, 8'd0, 8'd255, 1'b0);
      // Block clear, and first of block ignored on a read
      settle();
      write_config(1'b0, 16'h0123);
      send_item(iqdh_pkg::FUNC_ACCUM, 8'd255, 8'd0, 1'b0);
      send_item(iqdh_pkg::FUNC_ACCUM, 8'd0, 8'd255, 1'b1);
      send_item(iqdh_pkg::FUNC_ACCUM, 8'd0, 8'd255, 1'b0);
      send_item(iqdh_pkg::FUNC_READ, 8'd255, 8'd0, 1'b0);
      send_item(iqdh_pkg::FUNC_READ, 8'd0, 8'd255, 1'b1);
      send_item(iqdh_pkg::FUNC_READ, 8'd0, 8'd255, 1'b0);
      // Paused: accumulates and their clears dropped, reads still served
      settle();
      write_config(1'b1, 16'h0123);
      send_item(iqdh_pkg::FUNC_ACCUM, 8'd0, 8'd255, 1'b1);
      send_item(iqdh_pkg::FUNC_ACCUM, 8'd255, 8'd0, 1'b0);
      send_item(iqdh_pkg::FUNC_READ, 8'd0, 8'd255, 1'b0);
      send_item(iqdh_pkg::FUNC_READ, 8'd255, 8'd0, 1'b0);
      settle();
      write_config(1'b0, iqdh_pkg::STEP_RESET);
      send_item(iqdh_pkg::FUNC_ACCUM, 8'd255, 8'd255, 1'b0);
      send_item(iqdh_pkg::FUNC_READ, 8'd255, 8'd255, 1'b0);

      for (p = 0; p < PHASES; p++) begin
         settle();
         case (p / 4)
            0: begin
               send_idle = 9;
               recv_idle = 48;
            end
            1: begin
               send_idle = 48;
               recv_idle = 9;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         pz = 1'b0;
         case (p % 6)
            0: step = 16'h7FFF;
            1: step = -16'($urandom_range(1, 8000));
            2: begin
               step = iqdh_pkg::STEP_W'($urandom_range(1, 3000));
               pz = 1'b1;
            end
            3: step = 16'h8000;
            4: step = iqdh_pkg::STEP_W'($urandom_range(0, 65535));
            default: step = iqdh_pkg::STEP_RESET;
         endcase
         write_config(pz, step);
         repeat (ITEMS_PER_PHASE) random_item();
      end
      settle();

      $display("covered %0d reads and %0d accumulates (%0d block clears) over %0d settings",
               n_reads, n_accums, n_clears, n_settings);
      $display("stalls on either side in both ratios, then a stretch at full rate");
      if (fail_count == 0 && pending == 0)
         $display("iq_density_histogram_tb OK");
      else
         $display("iq_density_histogram_tb NOT OK");
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * 2 * CLOCK_HALF);
      $display("iq_density_histogram_tb NOT OK");
      $finish;
   end

endmodule

>>> iq_density_histogram.f
src/iqdh_pkg.sv
src/iqdh_ram.sv
src/iq_density_histogram.sv
test/iqdh_density_checker.sv
test/iq_density_histogram_tb.sv
